// ===== hw/rtl/sfq_pkg.sv =====
// Shared types and constants for the searchable FIFO queue.
// Request kinds, status codes, cell operations and cell control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfq_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_POP   = 3'd1,
    KIND_FRONT = 3'd2,
    KIND_FIND  = 3'd3,
    KIND_SWAP  = 3'd4,
    KIND_AT    = 3'd5,
    KIND_CLEAR = 3'd6
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,
    CELL_PUSH  = 2'd2,
    CELL_SWAP  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     sel_a;
    logic     sel_b;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfq_ifs.sv =====
// Valid/ready channel interfaces for queue requests and responses.
// Depends on sfq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sfq_req_if;
  logic                        valid;
  logic                        ready;
  logic [sfq_pkg::KIND_W-1:0]  kind;
  logic [sfq_pkg::VALUE_W-1:0] value;
  logic [sfq_pkg::IDX_W-1:0]   index;

  modport source (output valid, output kind, output value, output index, input ready);
  modport sink   (input valid, input kind, input value, input index, output ready);
endinterface

interface sfq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sfq_pkg::STATUS_W-1:0] status;
  logic [sfq_pkg::VALUE_W-1:0]  data;
  logic [sfq_pkg::IDX_W-1:0]    position;
  logic [sfq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output data, output position,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sfq_cell.sv =====
// One storage cell of the queue chain: holds one word, takes a word from its
// upper neighbor on shift, from the push port, or from a neighbor on swap.
// Depends on sfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire sfq_pkg::cell_ctrl_t    ctrl,
  input  wire logic [DATA_WIDTH-1:0]  push_word,
  input  wire logic [DATA_WIDTH-1:0]  next_word,
  input  wire logic [DATA_WIDTH-1:0]  prev_word,
  output logic      [DATA_WIDTH-1:0]  word
);
  import sfq_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_SHIFT: word <= next_word;
      CELL_PUSH: begin
        if (ctrl.sel_a) word <= push_word;
      end
      CELL_SWAP: begin
        if (ctrl.sel_a) begin
          word <= next_word;
        end else if (ctrl.sel_b) begin
          word <= prev_word;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/searchable_fifo_queue.sv =====
// Channel  Dir  Fields                                   Transaction when
// req      in   kind, value, index                       req.valid && req.ready
// rsp      out  status, data, position, occupancy        rsp.valid && rsp.ready
//
// Push, pop, front, swap, clear, and find/at on an empty queue or bad index: the
// response is registered, valid in the cycle after acceptance. Other find/at requests
// rotate all DEPTH cells past cell 0, where compare and capture happen; ends in place.
// A new request is taken once the previous response is taken or leaves with it.
// Synchronous active-high reset empties the queue; stored words are not cleared.
// Depends on sfq_pkg, sfq_ifs and sfq_cell.
`timescale 1ns / 1ps
`default_nettype none

module searchable_fifo_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sfq_req_if.sink    req,
  sfq_rsp_if.source  rsp
);
  import sfq_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int PW   = $clog2(DEPTH);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [PW-1:0]         step;
  logic [PW-1:0]         target;
  logic [PW-1:0]         fpos;
  logic                  found;
  logic                  scan_find;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] hit;

  logic                  out_valid;
  status_t               out_status;
  logic [VALUE_W-1:0]    out_data;
  logic [IDX_W-1:0]      out_position;

  logic [DATA_WIDTH-1:0] words [DEPTH];
  cell_ctrl_t            cctl  [DEPTH];

  logic                  take;
  logic [DATA_WIDTH-1:0] key_in;
  logic [CMPW-1:0]       idx_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic                  empty;
  logic                  full;
  logic                  idx_bad;
  logic                  match_now;
  logic                  last_step;
  cell_op_t              cell_op;

  assign req.ready     = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.data      = out_data;
  assign rsp.position  = out_position;
  assign rsp.occupancy = OCC_W'(count);

  always_comb begin
    take      = req.valid && req.ready;
    key_in    = DATA_WIDTH'(req.value);
    idx_ext   = CMPW'(req.index);
    cnt_ext   = CMPW'(count);
    empty     = (count == '0);
    full      = (count == CW'(DEPTH));
    idx_bad   = (idx_ext >= cnt_ext);
    match_now = scan_find && !found && (CW'(step) < count) && (words[0] == key);
    last_step = (step == PW'(DEPTH - 1));
    cell_op   = CELL_HOLD;
    if (state == S_SCAN) begin
      cell_op = CELL_SHIFT;
    end else if (take) begin
      case (req.kind)
        KIND_PUSH: if (!full) cell_op = CELL_PUSH;
        KIND_POP:  if (!empty) cell_op = CELL_SHIFT;
        KIND_SWAP: if (!empty && (idx_ext != '0) && !idx_bad) cell_op = CELL_SWAP;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cctl[i].op    = cell_op;
      cctl[i].sel_a = (cell_op == CELL_PUSH) ? (count == CW'(i))
                                             : (idx_ext == CMPW'(i + 1));
      cctl[i].sel_b = (idx_ext == CMPW'(i));
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sfq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cctl[g]),
      .push_word (key_in),
      .next_word (words[(g + 1) % DEPTH]),
      .prev_word (words[(g + DEPTH - 1) % DEPTH]),
      .word      (words[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      step      <= '0;
      found     <= 1'b0;
      scan_find <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            out_valid    <= 1'b1;
            out_status   <= ST_OK;
            out_data     <= '0;
            out_position <= '0;
            case (req.kind)
              KIND_PUSH: begin
                if (full) out_status <= ST_FULL;
                else count <= count + CW'(1);
              end
              KIND_POP: begin
                if (empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  out_data <= VALUE_W'(words[0]);
                  count    <= count - CW'(1);
                end
              end
              KIND_FRONT: begin
                if (empty) out_status <= ST_EMPTY;
                else out_data <= VALUE_W'(words[0]);
              end
              KIND_FIND: begin
                if (empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  out_valid <= 1'b0;
                  state     <= S_SCAN;
                  scan_find <= 1'b1;
                  key       <= key_in;
                  step      <= '0;
                  found     <= 1'b0;
                end
              end
              KIND_SWAP: begin
                if (empty) out_status <= ST_EMPTY;
                else if ((idx_ext == '0) || idx_bad) out_status <= ST_BAD_INDEX;
              end
              KIND_AT: begin
                if (empty) begin
                  out_status <= ST_EMPTY;
                end else if (idx_bad) begin
                  out_status <= ST_BAD_INDEX;
                end else begin
                  out_valid <= 1'b0;
                  state     <= S_SCAN;
                  scan_find <= 1'b0;
                  target    <= PW'(idx_ext);
                  step      <= '0;
                  found     <= 1'b0;
                end
              end
              KIND_CLEAR: count <= '0;
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (match_now) begin
            found <= 1'b1;
            fpos  <= step;
          end
          if (!scan_find && (step == target)) hit <= words[0];
          step <= step + PW'(1);
          if (last_step) begin
            state        <= S_IDLE;
            out_valid    <= 1'b1;
            out_status   <= ST_OK;
            out_data     <= '0;
            out_position <= '0;
            if (scan_find) begin
              if (found) begin
                out_position <= IDX_W'(fpos);
              end else if (match_now) begin
                out_position <= IDX_W'(step);
              end else begin
                out_status <= ST_NOT_FOUND;
              end
            end else begin
              out_data <= VALUE_W'((step == target) ? words[0] : hit);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
